### hw/rtl/rfv_pkg.sv
// rfv_pkg: shared types, constants and the crc-32 byte step for the record validator
// no dependencies

package rfv_pkg;

  localparam logic [31:0] MAGIC_WORD    = 32'h5341_4651;
  localparam logic [31:0] CRC_POLY      = 32'hedb8_8320;
  localparam logic [31:0] CRC_PRESET    = 32'hffff_ffff;
  localparam logic [16:0] HDR_BYTES     = 17'd10;
  localparam logic [16:0] TRL_BYTES     = 17'd4;
  localparam logic [16:0] MIN_BYTES     = HDR_BYTES + TRL_BYTES;
  localparam logic [16:0] COUNT_TOP     = 17'h1_ffff;
  localparam logic [16:0] SEQ_START     = 17'd4;
  localparam logic [16:0] LEN_START     = 17'd8;
  localparam logic [15:0] PAYLOAD_MAX   = 16'd256;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_SHORT   = 3'd1,
    ERR_MAGIC   = 3'd2,
    ERR_LEN_MAX = 3'd3,
    ERR_SIZE    = 3'd4,
    ERR_CRC     = 3'd5
  } err_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        record_ok;
    err_e        error_code;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } head_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### hw/rtl/rfv_front.sv
// rfv_front: accepts record beats, tracks header fields and crc, forms results
// depends on rfv_pkg

module rfv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  logic           crc_en_i,
  output rfv_pkg::push_t push_o
);

  logic [16:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [31:0] stored_q, stored_d;
  logic [16:0] body_end;
  logic        in_body;
  logic        accept;
  rfv_pkg::err_e err;

  assign accept = in_valid_i && !in_stall_i;

  always_comb begin
    magic_d = magic_q;
    seq_d   = seq_q;
    len_d   = len_q;
    if (cnt_q < rfv_pkg::SEQ_START) begin
      magic_d[{cnt_q[1:0], 3'b000} +: 8] = magic_q[{cnt_q[1:0], 3'b000} +: 8] | data_byte_i;
    end else if (cnt_q < rfv_pkg::LEN_START) begin
      seq_d[{cnt_q[1:0], 3'b000} +: 8] = seq_q[{cnt_q[1:0], 3'b000} +: 8] | data_byte_i;
    end else if (cnt_q < rfv_pkg::HDR_BYTES) begin
      len_d[{cnt_q[0], 3'b000} +: 8] = len_q[{cnt_q[0], 3'b000} +: 8] | data_byte_i;
    end
    body_end = rfv_pkg::HDR_BYTES + {1'b0, len_d};
    in_body  = cnt_q < body_end;
    crc_d    = ((cnt_q < rfv_pkg::HDR_BYTES) || in_body) ?
               rfv_pkg::crc_byte(crc_q, data_byte_i) : crc_q;
    stored_d = {data_byte_i, stored_q[31:8]};
    cnt_d    = (cnt_q == rfv_pkg::COUNT_TOP) ? cnt_q : cnt_q + 17'd1;

    if (cnt_d < rfv_pkg::MIN_BYTES) begin
      err = rfv_pkg::ERR_SHORT;
    end else if (magic_d != rfv_pkg::MAGIC_WORD) begin
      err = rfv_pkg::ERR_MAGIC;
    end else if (len_d > rfv_pkg::PAYLOAD_MAX) begin
      err = rfv_pkg::ERR_LEN_MAX;
    end else if (cnt_d != body_end + rfv_pkg::TRL_BYTES) begin
      err = rfv_pkg::ERR_SIZE;
    end else if (crc_en_i && (stored_d != ~crc_d)) begin
      err = rfv_pkg::ERR_CRC;
    end else begin
      err = rfv_pkg::ERR_OK;
    end

    push_o = '0;
    if (last_byte_i) begin
      push_o.valid                = accept;
      push_o.data.kind            = rfv_pkg::KIND_VERDICT;
      push_o.data.record_ok       = (err == rfv_pkg::ERR_OK);
      push_o.data.error_code      = err;
      push_o.data.sequence_number = seq_d;
      push_o.data.payload_length  = len_d;
    end else if ((cnt_q >= rfv_pkg::HDR_BYTES) && in_body) begin
      push_o.valid             = accept;
      push_o.data.kind         = rfv_pkg::KIND_PAYLOAD;
      push_o.data.payload_byte = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      crc_q    <= rfv_pkg::CRC_PRESET;
      magic_q  <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      stored_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        cnt_q    <= '0;
        crc_q    <= rfv_pkg::CRC_PRESET;
        magic_q  <= '0;
        seq_q    <= '0;
        len_q    <= '0;
        stored_q <= '0;
      end else begin
        cnt_q    <= cnt_d;
        crc_q    <= crc_d;
        magic_q  <= magic_d;
        seq_q    <= seq_d;
        len_q    <= len_d;
        stored_q <= stored_d;
      end
    end
  end

endmodule

### hw/rtl/rfv_queue.sv
// rfv_queue: short result queue between the front and back parts
// depends on rfv_pkg

module rfv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rfv_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output rfv_pkg::head_t head_o
);

  rfv_pkg::result_t                 mem_q [rfv_pkg::QDEPTH];
  logic [rfv_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rfv_pkg::QCNT_W-1:0]       cnt_q;
  logic                             do_pop;

  assign full_o       = (cnt_q == rfv_pkg::QCNT_W'(rfv_pkg::QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [rfv_pkg::QPTR_W-1:0] ptr_next(
      input logic [rfv_pkg::QPTR_W-1:0] p);
    return (p == rfv_pkg::QPTR_W'(rfv_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i.valid && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rfv_pkg::QCNT_W'(rfv_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.valid)
    else $error("push into full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointer gap");

endmodule

### hw/rtl/rfv_back.sv
// rfv_back: output register that drains the result queue onto the output channel
// depends on rfv_pkg

module rfv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfv_pkg::head_t     head_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output rfv_pkg::result_t   out_data_o
);

  logic             valid_q;
  rfv_pkg::result_t data_q;

  assign pop_o       = head_i.valid && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

### hw/rtl/record_frame_validator.sv
// record_frame_validator: top level, front part, result queue and output register
// depends on rfv_pkg, rfv_front, rfv_queue, rfv_back
//
//   channel | handshake              | payload
//   in      | in_valid_i / in_stall_o  | data_byte_i, last_byte_i
//   out     | out_valid_o / out_stall_i| result_kind_o .. payload_length_o
//   cfg     | cfg_we_i                 | cfg_wdata_i (check_crc_enable)
//
// one beat per cycle while in_stall_o is low; byte-wide crc step is combinational
// the verdict is combinational; a result passes the queue, then the output register
// reset clears the record state and sets the crc check on; no clearing pass
// in_stall_o rises only when the two-entry queue is full

module record_frame_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        record_ok_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] sequence_number_o,
  output logic [15:0] payload_length_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic             crc_en_q;
  logic             q_full;
  logic             pop;
  rfv_pkg::push_t   push;
  rfv_pkg::head_t   head;
  rfv_pkg::result_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      crc_en_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full;

  rfv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (q_full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .crc_en_i    (crc_en_q),
    .push_o      (push)
  );

  rfv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  rfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign result_kind_o     = out_data.kind;
  assign payload_byte_o    = out_data.payload_byte;
  assign record_ok_o       = out_data.record_ok;
  assign error_code_o      = out_data.error_code;
  assign sequence_number_o = out_data.sequence_number;
  assign payload_length_o  = out_data.payload_length;

endmodule
